FILE: src/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/teah_pkg.sv
// shared types and constants of the edge adjacency hash block
package teah_pkg;

    localparam int BUCKETS       = 512;
    localparam int BUCKET_BITS   = $clog2(BUCKETS);
    localparam int ENTRIES       = 4096;
    localparam int ENTRY_BITS    = $clog2(ENTRIES);
    localparam int USED_BITS     = ENTRY_BITS + 1;
    localparam int TRI_BITS      = 12;
    localparam int SLOT_BITS     = 2;
    localparam int VERTEX_BITS   = 16;
    localparam int HASH_BITS     = VERTEX_BITS + 6;
    localparam int MARK_BITS     = 4;
    localparam int NMARK_BITS    = 2;
    localparam int IN_BITS       = 48;
    localparam int OUT_BITS      = 24;

    localparam logic [HASH_BITS-1:0]  HASH_LO_MUL    = HASH_BITS'(13);
    localparam logic [HASH_BITS-1:0]  HASH_HI_MUL    = HASH_BITS'(17);
    localparam logic [MARK_BITS-1:0]  MARK_NONE      = MARK_BITS'(0);
    localparam logic [MARK_BITS-1:0]  MARK_ORIENTED  = MARK_BITS'(1);
    localparam logic [MARK_BITS-1:0]  MARK_OUTSIDE   = MARK_BITS'(9);
    localparam logic [NMARK_BITS-1:0] NMARK_NONE     = NMARK_BITS'(0);
    localparam logic [NMARK_BITS-1:0] NMARK_ORIENTED = NMARK_BITS'(3);

    typedef struct packed {
        logic [TRI_BITS-1:0]    tri_idx;
        logic [SLOT_BITS-1:0]   slot;
        logic                   outside;
        logic [VERTEX_BITS-1:0] lo;
        logic [VERTEX_BITS-1:0] hi;
        logic [ENTRY_BITS-1:0]  next;
        logic                   has_next;
    } entry_t;

    typedef struct packed {
        logic                  valid;
        logic [ENTRY_BITS-1:0] head;
    } bucket_t;

    typedef struct packed {
        logic                  matched;
        logic [TRI_BITS-1:0]   neighbour_triangle;
        logic [SLOT_BITS-1:0]  neighbour_edge;
        logic [MARK_BITS-1:0]  own_mark;
        logic [NMARK_BITS-1:0] neighbour_mark;
        logic                  own_outside;
        logic                  table_full;
    } result_t;

    typedef enum logic [2:0] {
        S_CLR_RST,
        S_IDLE,
        S_CLR_MESH,
        S_BKT,
        S_BCHK,
        S_ECHK,
        S_INS,
        S_OUT
    } state_t;

    typedef struct packed {
        logic latch;
        logic clr_step;
        logic bkt_rd;
        logic ent_rd_head;
        logic ent_rd_next;
        logic hit;
        logic insert;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_mesh;
        logic clr_last;
        logic bkt_valid;
        logic match;
        logic has_next;
        logic out_free;
    } status_t;

endpackage

FILE: src/teah_ctrl.sv
// controller state machine of the edge adjacency hash block
module teah_ctrl
    import teah_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR_RST;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_RST: begin
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) state_next = st.in_mesh ? S_CLR_MESH : S_BKT;
            end
            S_CLR_MESH: begin
                if (st.clr_last) state_next = S_BKT;
            end
            S_BKT:  state_next = S_BCHK;
            S_BCHK: state_next = st.bkt_valid ? S_ECHK : S_INS;
            S_ECHK: begin
                priority if (st.match) state_next = S_OUT;
                else if (!st.has_next) state_next = S_INS;
                else state_next = S_ECHK;
            end
            S_INS:  state_next = S_OUT;
            S_OUT: begin
                if (st.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLR_RST:  cmd.clr_step = 1'b1;
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            S_CLR_MESH: cmd.clr_step = 1'b1;
            S_BKT:      cmd.bkt_rd = 1'b1;
            S_BCHK:     cmd.ent_rd_head = st.bkt_valid;
            S_ECHK: begin
                cmd.hit         = st.match;
                cmd.ent_rd_next = !st.match && st.has_next;
            end
            S_INS:      cmd.insert = 1'b1;
            S_OUT:      cmd.load_out = st.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

FILE: src/teah_dp.sv
// datapath of the edge adjacency hash block: bucket and entry memories, result register
module teah_dp
    import teah_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata,
    input  cmd_t                cmd,
    output status_t             st
);

    bucket_t bkt_mem [BUCKETS];
    entry_t  ent_mem [ENTRIES];

    logic [TRI_BITS-1:0]    tri_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic                   outside_reg;
    logic [VERTEX_BITS-1:0] lo_reg, hi_reg;
    logic [BUCKET_BITS-1:0] bucket_reg;
    logic [BUCKET_BITS-1:0] clr_cnt_reg;
    logic [USED_BITS-1:0]   used_reg;
    bucket_t                bkt_q_reg;
    entry_t                 ent_q_reg;
    result_t                res_reg;
    logic                   m_valid_reg;
    result_t                m_res_reg;

    logic [VERTEX_BITS-1:0] in_va, in_vb, in_lo, in_hi;
    logic [HASH_BITS-1:0]   hash_sum;
    logic                   pool_full;
    entry_t                 new_entry;

    assign in_va    = s_tdata[30:15];
    assign in_vb    = s_tdata[46:31];
    assign in_lo    = (in_va < in_vb) ? in_va : in_vb;
    assign in_hi    = (in_va < in_vb) ? in_vb : in_va;
    assign hash_sum = HASH_LO_MUL * HASH_BITS'(in_lo) + HASH_HI_MUL * HASH_BITS'(in_hi);
    assign pool_full = (used_reg == USED_BITS'(ENTRIES));

    always_comb begin
        new_entry          = '0;
        new_entry.tri_idx  = tri_reg;
        new_entry.slot     = slot_reg;
        new_entry.outside  = outside_reg;
        new_entry.lo       = lo_reg;
        new_entry.hi       = hi_reg;
        new_entry.next     = bkt_q_reg.head;
        new_entry.has_next = bkt_q_reg.valid;
    end

    // item registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            tri_reg     <= s_tdata[12:1];
            slot_reg    <= s_tdata[14:13];
            outside_reg <= s_tdata[47];
            lo_reg      <= in_lo;
            hi_reg      <= in_hi;
            bucket_reg  <= hash_sum[BUCKET_BITS-1:0];
        end
    end

    // clear counter and pool fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            used_reg    <= '0;
        end else begin
            if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.latch && s_tdata[0]) begin
                used_reg <= '0;
            end else if (cmd.insert && !pool_full) begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    // bucket memory
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            bkt_mem[clr_cnt_reg] <= '0;
        end else if (cmd.insert && !pool_full) begin
            bkt_mem[bucket_reg] <= '{valid: 1'b1, head: used_reg[ENTRY_BITS-1:0]};
        end
        if (cmd.bkt_rd) bkt_q_reg <= bkt_mem[bucket_reg];
    end

    // entry memory
    always_ff @(posedge aclk) begin
        if (cmd.insert && !pool_full) ent_mem[used_reg[ENTRY_BITS-1:0]] <= new_entry;
        if (cmd.ent_rd_head) begin
            ent_q_reg <= ent_mem[bkt_q_reg.head];
        end else if (cmd.ent_rd_next) begin
            ent_q_reg <= ent_mem[ent_q_reg.next];
        end
    end

    // result under construction
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            res_reg <= '0;
        end else if (cmd.hit) begin
            res_reg.matched            <= 1'b1;
            res_reg.neighbour_triangle <= ent_q_reg.tri_idx;
            res_reg.neighbour_edge     <= ent_q_reg.slot;
            res_reg.own_mark           <= ent_q_reg.outside ? MARK_OUTSIDE : MARK_ORIENTED;
            res_reg.neighbour_mark     <= ent_q_reg.outside ? NMARK_NONE : NMARK_ORIENTED;
            res_reg.own_outside        <= ent_q_reg.outside;
        end else if (cmd.insert) begin
            res_reg.own_mark    <= outside_reg ? MARK_OUTSIDE : MARK_NONE;
            res_reg.own_outside <= outside_reg;
            res_reg.table_full  <= pool_full;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) m_res_reg <= res_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0,
                       m_res_reg.table_full,
                       m_res_reg.own_outside,
                       m_res_reg.neighbour_mark,
                       m_res_reg.own_mark,
                       m_res_reg.neighbour_edge,
                       m_res_reg.neighbour_triangle,
                       m_res_reg.matched};

    always_comb begin
        st           = '0;
        st.in_mesh   = s_tdata[0];
        st.clr_last  = (clr_cnt_reg == BUCKET_BITS'(BUCKETS - 1));
        st.bkt_valid = bkt_q_reg.valid;
        st.match     = (ent_q_reg.lo == lo_reg) && (ent_q_reg.hi == hi_reg);
        st.has_next  = ent_q_reg.has_next;
        st.out_free  = !m_valid_reg || m_tready;
    end

endmodule

FILE: src/triangle_edge_adjacency_hash_top.sv
// Triangle edge adjacency matcher on a chained hash table. Each edge is hashed
// by its ordered vertex pair; the bucket chain is walked newest first, one
// entry per cycle through the entry memory's single read port. An edge that
// matches is sent to the output after the chain walk; one not found is inserted
// at the head of its bucket's chain unless the pool is full. The result is
// registered in the output register, and a result still waiting there holds
// the block until taken. After reset, and after accepting an edge with new_mesh
// set, the bucket memory is swept clear while no edge is accepted.
module triangle_edge_adjacency_hash_top
    import teah_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // new_mesh, triangle_index, edge_slot, vertex_a, vertex_b, edge_outside
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // matched, neighbour_triangle, neighbour_edge, own_mark, neighbour_mark,
    // own_outside, table_full, zero pad
    output logic [OUT_BITS-1:0] m_tdata
);

    cmd_t    cmd;
    status_t st;

    teah_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    teah_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

FILE: src/teah_chk.sv
// port checker of the edge adjacency hash block
`include "assert_macros.svh"

module teah_chk
    import teah_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [IN_BITS-1:0]  s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `ASSERT_IMPLIES(a_unmatched_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[14:1] == 14'd0 && m_tdata[20:19] == 2'd0, "unmatched result carries neighbour")
    `ASSERT_IMPLIES(a_full_miss, aclk, aresetn, m_tvalid && m_tdata[22], !m_tdata[0], "full on a match")
    `ASSERT_IMPLIES(a_mark_code, aclk, aresetn, m_tvalid, m_tdata[18:15] == 4'd0 || m_tdata[18:15] == 4'd1 || m_tdata[18:15] == 4'd9, "bad mark")
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted twice in a row")

endmodule

bind triangle_edge_adjacency_hash_top teah_chk u_teah_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/tb_triangle_edge_adjacency_hash_top.sv
// testbench for the edge adjacency hash block: queued stimulus, self-checking result monitor
module tb_triangle_edge_adjacency_hash_top;
    import teah_pkg::*;

    typedef struct {
        logic                   new_mesh;
        logic [TRI_BITS-1:0]    tri_idx;
        logic [SLOT_BITS-1:0]   slot;
        logic [VERTEX_BITS-1:0] va;
        logic [VERTEX_BITS-1:0] vb;
        logic                   outside;
    } edge_item_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;

    triangle_edge_adjacency_hash_top dut (.*);

    always #4 aclk = ~aclk;

    // shadow copy of the hash table
    logic                  mdl_bkt_valid [BUCKETS];
    logic [ENTRY_BITS-1:0] mdl_bkt_head [BUCKETS];
    entry_t                mdl_entries [ENTRIES];
    int unsigned           mdl_used;

    edge_item_t edge_queue[$];
    result_t    expected_results[$];
    int         errors = 0;
    int         results_seen = 0;
    int         stall_cycles = 0;
    logic       in_fire = 1'b0;
    logic       stim_done = 1'b0;

    // driver and receiver pacing state
    int         gap = 0;
    logic       bursting = 1'b0;
    int         wait_cnt = 0;
    int         hold_cnt = 0;
    logic       held = 1'b0;

    function automatic result_t match_edge(edge_item_t it);
        result_t r;
        logic [VERTEX_BITS-1:0] lo, hi;
        int unsigned bkt, idx, steps;
        logic have, found;
        r = '0;
        found = 1'b0;
        if (it.new_mesh) begin
            foreach (mdl_bkt_valid[i]) mdl_bkt_valid[i] = 1'b0;
            mdl_used = 0;
        end
        lo = (it.va < it.vb) ? it.va : it.vb;
        hi = (it.va < it.vb) ? it.vb : it.va;
        bkt = (13 * int'(lo) + 17 * int'(hi)) % BUCKETS;
        have = mdl_bkt_valid[bkt];
        idx = mdl_bkt_head[bkt];
        for (steps = 0; have && steps < mdl_used; steps++) begin
            if (idx >= mdl_used) break;
            if (mdl_entries[idx].lo == lo && mdl_entries[idx].hi == hi) begin
                found = 1'b1;
                r.matched = 1'b1;
                r.neighbour_triangle = mdl_entries[idx].tri_idx;
                r.neighbour_edge = mdl_entries[idx].slot;
                if (mdl_entries[idx].outside) begin
                    r.own_mark = MARK_OUTSIDE;
                    r.own_outside = 1'b1;
                end else begin
                    r.own_mark = MARK_ORIENTED;
                    r.neighbour_mark = NMARK_ORIENTED;
                end
                break;
            end
            have = mdl_entries[idx].has_next;
            idx = mdl_entries[idx].next;
        end
        if (!found) begin
            if (it.outside) begin
                r.own_mark = MARK_OUTSIDE;
                r.own_outside = 1'b1;
            end
            if (mdl_used >= ENTRIES) begin
                r.table_full = 1'b1;
            end else begin
                mdl_entries[mdl_used] = '{tri_idx: it.tri_idx, slot: it.slot,
                    outside: it.outside, lo: lo, hi: hi, next: mdl_bkt_head[bkt],
                    has_next: mdl_bkt_valid[bkt]};
                mdl_bkt_head[bkt] = ENTRY_BITS'(mdl_used);
                mdl_bkt_valid[bkt] = 1'b1;
                mdl_used++;
            end
        end
        return r;
    endfunction

    task automatic add_edge(logic nm, int t, int sl, int a, int b, logic o);
        edge_item_t it;
        it.new_mesh = nm;
        it.tri_idx = TRI_BITS'(t);
        it.slot = SLOT_BITS'(sl);
        it.va = VERTEX_BITS'(a);
        it.vb = VERTEX_BITS'(b);
        it.outside = o;
        edge_queue.push_back(it);
    endtask

    // handshake sampling, prediction and checking
    always @(posedge aclk) begin
        result_t act, exp_r;
        edge_item_t it;
        in_fire <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            it.new_mesh = s_tdata[0];
            it.tri_idx = s_tdata[12:1];
            it.slot = s_tdata[14:13];
            it.va = s_tdata[30:15];
            it.vb = s_tdata[46:31];
            it.outside = s_tdata[47];
            expected_results.push_back(match_edge(it));
        end
        if (aresetn && m_tvalid && m_tready) begin
            act.matched = m_tdata[0];
            act.neighbour_triangle = m_tdata[12:1];
            act.neighbour_edge = m_tdata[14:13];
            act.own_mark = m_tdata[18:15];
            act.neighbour_mark = m_tdata[20:19];
            act.own_outside = m_tdata[21];
            act.table_full = m_tdata[22];
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, act);
                errors <= errors + 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (act != exp_r) begin
                    $display("%0t: result differs, expected %h, actual %h",
                             $time, exp_r, act);
                    errors <= errors + 1;
                end
            end
        end
    end

    // edge driver
    always @(negedge aclk) begin
        edge_item_t it;
        logic nv;
        logic [IN_BITS-1:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (aresetn && (!s_tvalid || in_fire)) begin
            nv = 1'b0;
            if (in_fire) begin
                if ($urandom_range(0, 49) == 0) bursting = !bursting;
                gap = bursting ? 0 : $urandom_range(0, 14);
            end
            if (gap > 0) begin
                gap--;
            end else if (edge_queue.size() > 0) begin
                it = edge_queue.pop_front();
                nd = {it.outside, it.vb, it.va, it.slot, it.tri_idx, it.new_mesh};
                nv = 1'b1;
            end
        end
        s_tvalid <= nv;
        s_tdata <= nd;
    end

    // result receiver with one long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) wait_cnt = $urandom_range(0, 14);
            if (results_seen >= 100 && !held) begin
                held = 1'b1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (wait_cnt > 0) begin
                wait_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= 20000) begin
            $display("triangle_edge_adjacency_hash_top: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int n, base, span;
        logic nm;
        foreach (mdl_bkt_valid[i]) mdl_bkt_valid[i] = 1'b0;
        foreach (mdl_bkt_head[i]) mdl_bkt_head[i] = '0;
        mdl_used = 0;

        // directed edges
        add_edge(1'b1, 0, 0, 0, 0, 1'b0);
        add_edge(1'b0, 4095, 3, 0, 0, 1'b1);
        add_edge(1'b0, 4095, 3, 65535, 65535, 1'b1);
        add_edge(1'b0, 1, 1, 65535, 65535, 1'b0);
        add_edge(1'b0, 2, 2, 100, 200, 1'b0);
        add_edge(1'b0, 3, 0, 200, 100, 1'b1);
        add_edge(1'b0, 4, 1, 100, 200, 1'b0);
        add_edge(1'b0, 5, 2, 0, 65535, 1'b1);
        add_edge(1'b0, 6, 0, 65535, 0, 1'b0);
        add_edge(1'b0, 7, 1, 43690, 21845, 1'b0);
        add_edge(1'b0, 8, 3, 21845, 43690, 1'b1);
        add_edge(1'b1, 9, 1, 100, 200, 1'b0);
        add_edge(1'b0, 10, 2, 0, 0, 1'b0);

        // random meshes sharing a small vertex neighbourhood
        n = 0;
        base = 0;
        span = 8;
        while (n < 1600) begin
            nm = ($urandom_range(0, 99) < 3);
            if (nm) begin
                base = $urandom_range(0, 65535);
                span = $urandom_range(1, 12);
            end
            if ($urandom_range(0, 99) < 12)
                add_edge(nm, $urandom_range(0, 4095), $urandom_range(0, 3),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         1'($urandom_range(0, 1)));
            else
                add_edge(nm, $urandom_range(0, 4095), $urandom_range(0, 3),
                         base + $urandom_range(0, span), base + $urandom_range(0, span),
                         1'($urandom_range(0, 1)));
            n++;
        end

        add_edge(1'b1, 11, 2, 5, 6, 1'b1);
        add_edge(1'b0, 12, 0, 6, 5, 1'b0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (edge_queue.size() == 0);
        @(posedge aclk);
        wait (!s_tvalid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("triangle_edge_adjacency_hash_top: match");
        else
            $display("triangle_edge_adjacency_hash_top: mismatch");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/teah_pkg.sv
src/teah_ctrl.sv
src/teah_dp.sv
src/triangle_edge_adjacency_hash_top.sv
src/teah_chk.sv
dv/tb_triangle_edge_adjacency_hash_top.sv
